>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg
// Widths, request and status codes and the result record of the list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int OP_W      = 3;
    localparam int ELEM_W    = 32;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;
    localparam int OCNT_W    = 6;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
    localparam logic [OP_W-1:0] OP_TRAVERSE  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic [STAT_W-1:0]        status;
        logic signed [ELEM_W-1:0] value;
        logic [OCNT_W-1:0]        count;
        logic                     last;
    } res_t;

endpackage

>>> hw/rtl/positional_list_engine.sv
// ---------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with positional insert and delete.
// ---------------------------------------------------------------------------
// Requests come in on the s_ channel, results leave on the m_ channel; both
// move a request or result when tvalid and tready are high at a clock edge.
// One request is handled at a time; s_tready is low until its last result
// has been loaded into the output register.
// Edit requests give one result. An insert steps through a check, a
// registered read and a write per element moved by the shift, the final
// write and the reply; a delete through the check, a read and a write per
// moved element and the reply; a rejected edit goes from the check straight
// to the reply. A traverse reads each element from the store and then
// outputs it, tlast on the final element; an empty list gives one result
// with status empty.
// The output register lets the sequencer run on while a result waits; a
// stall on m_tready holds the next result in the sequencer until taken.
// Reset empties the list; store contents are never read before written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode[2:0], item_value[34:3], position[40:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], element_value[33:2], element_count[39:34]
    output logic        m_tlast    // last_result
);
    import ple_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t                     res;
    logic                     slot_free;
    logic                     mem_wr_en, mem_rd_en;
    logic [AW-1:0]            mem_wr_addr, mem_rd_addr;
    logic signed [ELEM_W-1:0] mem_wr_data, mem_rd_data;

    logic                     m_valid_reg;
    logic [STAT_W-1:0]        m_status_reg;
    logic signed [ELEM_W-1:0] m_value_reg;
    logic [OCNT_W-1:0]        m_count_reg;
    logic                     m_last_reg;

    assign slot_free = !m_valid_reg || m_tready;

    ple_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tdata[2:0]),
        .in_value    (s_tdata[34:3]),
        .in_pos      (s_tdata[40:35]),
        .slot_free   (slot_free),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ple_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: load a new result, drop the flag once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_status_reg <= res.status;
            m_value_reg  <= res.value;
            m_count_reg  <= res.count;
            m_last_reg   <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_value_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    `ASSERT_IMPL(res_no_overrun, res.valid, !m_valid_reg || m_tready, "result overwrites a pending one")

endmodule

>>> hw/rtl/ple_mem.sv
// ---------------------------------------------------------------------------
// ple_mem
// Element store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ple_mem #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [ple_pkg::ELEM_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic signed [ple_pkg::ELEM_W-1:0] rd_data
);
    import ple_pkg::*;

    logic signed [ELEM_W-1:0] mem [DEPTH];
    logic signed [ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ple_ctrl.sv
// ---------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: range checks, element shifting one slot at a time
// through a shared slot counter, and traversal.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_ctrl #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ple_pkg::OP_W-1:0]          in_opcode,
    input  logic signed [ple_pkg::ELEM_W-1:0] in_value,
    input  logic [ple_pkg::POS_W-1:0]         in_pos,
    input  logic                              slot_free,
    output ple_pkg::res_t                     res,
    output logic                              mem_wr_en,
    output logic [AW-1:0]                     mem_wr_addr,
    output logic signed [ple_pkg::ELEM_W-1:0] mem_wr_data,
    output logic                              mem_rd_en,
    output logic [AW-1:0]                     mem_rd_addr,
    input  logic signed [ple_pkg::ELEM_W-1:0] mem_rd_data
);
    import ple_pkg::*;

    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_UP_RD, S_UP_WR, S_WRITE,
        S_DN_RD, S_DN_WR, S_TRV_RD, S_TRV_OUT, S_REPLY
    } state_t;

    state_t                   state_reg, state_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic signed [ELEM_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [STAT_W-1:0]        status_reg, status_next;

    logic [CMPW-1:0] pos_ext, cnt_ext;
    logic [CW-1:0]   ins_idx, del_idx, k_dec, k_inc, rd_k;
    logic            trv_last;

    assign pos_ext  = CMPW'(pos_reg);
    assign cnt_ext  = CMPW'(count_reg);
    assign k_dec    = k_reg - CW'(1);
    assign k_inc    = k_reg + CW'(1);
    assign trv_last = (CMPW'(k_reg) + CMPW'(1)) == cnt_ext;

    always_comb begin
        case (op_reg)
            OP_INS_FRONT: ins_idx = '0;
            OP_INS_BACK:  ins_idx = count_reg;
            default:      ins_idx = CW'(pos_ext - CMPW'(1));
        endcase
        case (op_reg)
            OP_DEL_FRONT: del_idx = '0;
            OP_DEL_BACK:  del_idx = count_reg - CW'(1);
            default:      del_idx = CW'(pos_ext - CMPW'(1));
        endcase
    end

    // shared slot counter drives the read address
    always_comb begin
        case (state_reg)
            S_UP_RD: rd_k = k_dec;
            S_DN_RD: rd_k = k_inc;
            default: rd_k = k_reg;
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign mem_rd_en   = (state_reg == S_UP_RD) || (state_reg == S_DN_RD) ||
                         (state_reg == S_TRV_RD);
    assign mem_rd_addr = rd_k[AW-1:0];
    assign mem_wr_en   = (state_reg == S_UP_WR) || (state_reg == S_DN_WR) ||
                         (state_reg == S_WRITE);
    assign mem_wr_addr = (state_reg == S_WRITE) ? idx_reg[AW-1:0] : k_reg[AW-1:0];
    assign mem_wr_data = (state_reg == S_WRITE) ? val_reg : mem_rd_data;

    always_comb begin
        res.valid  = ((state_reg == S_REPLY) || (state_reg == S_TRV_OUT)) && slot_free;
        res.status = (state_reg == S_TRV_OUT) ? ST_OK : status_reg;
        res.value  = (state_reg == S_TRV_OUT) ? mem_rd_data : '0;
        res.count  = OCNT_W'(count_reg);
        res.last   = (state_reg == S_REPLY) || trv_last;
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_opcode;
                    val_next    = in_value;
                    pos_next    = in_pos;
                    status_next = ST_OK;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_REPLY;
                case (op_reg)
                    OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                        if ((op_reg == OP_INS_POS) &&
                            ((pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1)))) begin
                            status_next = ST_BADPOS;
                        end else if (count_reg >= CW'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            idx_next   = ins_idx;
                            k_next     = count_reg;
                            state_next = (count_reg > ins_idx) ? S_UP_RD : S_WRITE;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (del_idx < count_reg - CW'(1)) begin
                            k_next     = del_idx;
                            state_next = S_DN_RD;
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_DEL_POS: begin
                        if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                            status_next = ST_BADPOS;
                        end else if (del_idx < count_reg - CW'(1)) begin
                            k_next     = del_idx;
                            state_next = S_DN_RD;
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_TRAVERSE: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            k_next     = '0;
                            state_next = S_TRV_RD;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_UP_RD: state_next = S_UP_WR;
            S_UP_WR: begin
                // slot k now holds slot k-1; step down toward the gap
                k_next     = k_dec;
                state_next = (k_dec > idx_reg) ? S_UP_RD : S_WRITE;
            end
            S_WRITE: begin
                count_next = count_reg + CW'(1);
                state_next = S_REPLY;
            end
            S_DN_RD: state_next = S_DN_WR;
            S_DN_WR: begin
                k_next = k_inc;
                if ((CMPW'(k_inc) + CMPW'(1)) < cnt_ext) begin
                    state_next = S_DN_RD;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_REPLY;
                end
            end
            S_TRV_RD: state_next = S_TRV_OUT;
            S_TRV_OUT: begin
                if (slot_free) begin
                    if (trv_last) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_inc;
                        state_next = S_TRV_RD;
                    end
                end
            end
            S_REPLY: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
        op_reg  <= op_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        k_reg   <= k_next;
    end

    `ASSERT_ALWAYS(count_in_range, count_reg <= CW'(DEPTH), "element count above depth")
    `ASSERT_IMPL(count_moves_on_edit, count_reg != $past(count_reg), ($past(state_reg) == S_WRITE) || ($past(state_reg) == S_DN_WR) || ($past(state_reg) == S_CHECK), "count changed outside an edit")
    `ASSERT_IMPL(traverse_not_empty, state_reg == S_TRV_OUT, count_reg != '0, "traverse output with empty list")

endmodule
